// ===== hw/rtl/srfc_pkg.sv =====
// Shared constants, result type and CRC step for the framed serial receiver.
package srfc_pkg;

  localparam int BUF_LEN = 32;
  localparam int ADDR_W  = $clog2(BUF_LEN);

  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] MIN_LEN  = 8'd5;
  localparam logic [7:0] HDR_RST  = 8'd2;
  localparam logic [7:0] TMO_RST  = 8'd10;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

  // Result event codes
  localparam logic [1:0] EV_PAYLOAD = 2'd0;
  localparam logic [1:0] EV_CRC_ERR = 2'd1;
  localparam logic [1:0] EV_TIMEOUT = 2'd2;
  localparam logic [1:0] EV_ABORT   = 2'd3;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [6:0]  command;
    logic [7:0]  msg_number;
    logic [7:0]  frame_length;
    logic [7:0]  data_byte;
    logic        has_data;
    logic        last;
    logic [15:0] crc_error_count;
  } srfc_res_t;

  // Reflected CRC register, data bits taken MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] val);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = val[i] ^ c[0];
      c  = {1'b0, c[7:1]} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/srfc_if.sv =====
// Valid/ready channel interfaces for receiver input and result streams.
interface srfc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface srfc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [6:0]  command;
  logic [7:0]  msg_number;
  logic [7:0]  frame_length;
  logic [7:0]  data_byte;
  logic        has_data;
  logic        last;
  logic [15:0] crc_error_count;

  modport source (output valid, output event_res, output command, output msg_number,
                  output frame_length, output data_byte, output has_data, output last,
                  output crc_error_count, input ready);
  modport sink (input valid, input event_res, input command, input msg_number,
                input frame_length, input data_byte, input has_data, input last,
                input crc_error_count, output ready);
endinterface

// ===== hw/rtl/srfc_out_fifo.sv =====
// Two-entry result queue that decouples the receiver from the result sink.
module srfc_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  srfc_pkg::srfc_res_t push_res,
  output logic                can_push,
  srfc_out_if.source          out_if
);
  import srfc_pkg::*;

  srfc_res_t  ent_r [2];
  srfc_res_t  head;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop      = out_if.valid && out_if.ready;
  assign can_push = (cnt_r != 2'd2);
  assign head     = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_res;
    end
  end

  assign out_if.valid           = (cnt_r != 2'd0);
  assign out_if.event_res       = head.event_res;
  assign out_if.command         = head.command;
  assign out_if.msg_number      = head.msg_number;
  assign out_if.frame_length    = head.frame_length;
  assign out_if.data_byte       = head.data_byte;
  assign out_if.has_data        = head.has_data;
  assign out_if.last            = head.last;
  assign out_if.crc_error_count = head.crc_error_count;

endmodule

// ===== hw/rtl/serial_frame_receiver_crc8_core.sv =====
// Framed serial receiver top level: header hunt, CRC-8 check, payload store and readout.
//
// Input channel (in_if): one request per received byte (kind 0) or timer tick (kind 1).
// Result channel (out_if): event results; an accepted frame gives one result per
// payload byte, the final one flagged by last. Configuration (cfg_*) sets the header
// byte (index 0) and the timeout reload (index 1); write only while the block is idle.
// An empty payload gives one result without data. Results are registered in the
// result queue before they show on out_if. Throughput: one request per cycle while no
// frame is being read out and the queue has room. After a CRC byte that matches, the N
// payload bytes are read through the registered read port of the payload memory,
// one per cycle while the queue has room, and in_if.ready stays low meanwhile.
// Results pass through a two-entry queue, so a request is still taken while a
// result waits; when the sink stalls and the queue is full, in_if.ready drops and
// the readout holds its place.
// Reset: registers return to header search with header 0x02 and reload 10; the
// payload memory is not cleared and needs no clearing pass, as every entry read out
// was written earlier in the same frame.
module serial_frame_receiver_crc8_core (
  input  logic                             clk,
  input  logic                             rst_n,
  srfc_in_if.sink                          in_if,
  srfc_out_if.source                       out_if,
  input  logic                             cfg_wr_en,
  input  logic [srfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srfc_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
  import srfc_pkg::*;

  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_CMD    = 3'd1;
  localparam logic [2:0] PH_LEN    = 3'd2;
  localparam logic [2:0] PH_NUM    = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_CRC    = 3'd5;
  localparam logic [2:0] PH_READ   = 3'd6;

  logic [7:0]        hdr_r, tmo_r;
  logic [2:0]        phase_r, phase_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        crc_r, crc_nxt;
  logic [6:0]        cmd_r, cmd_nxt;
  logic [7:0]        num_r, num_nxt;
  logic [ADDR_W-1:0] pidx_r, pidx_nxt;
  logic [7:0]        ticks_r, ticks_nxt;
  logic [15:0]       errs_r, errs_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0]        pay_mem_r [BUF_LEN];
  logic [7:0]        rd_data_r;

  logic      in_acc;
  logic      can_push;
  logic      push;
  logic      restart;
  logic      mem_we;
  logic      rd_last;
  logic [7:0] b;
  srfc_res_t res;

  assign b            = in_if.rx_byte;
  assign in_if.ready  = (phase_r != PH_READ) && can_push;
  assign in_acc       = in_if.valid && in_if.ready;
  assign rd_last      = ((rd_idx_r + ADDR_W'(1)) == pidx_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= HDR_RST;
      tmo_r <= TMO_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_HEADER:  hdr_r <= cfg_wr_data;
        REG_TIMEOUT: tmo_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    cmd_nxt    = cmd_r;
    num_nxt    = num_r;
    pidx_nxt   = pidx_r;
    ticks_nxt  = ticks_r;
    errs_nxt   = errs_r;
    rd_idx_nxt = rd_idx_r;
    restart    = 1'b0;
    push       = 1'b0;
    mem_we     = 1'b0;

    res.event_res       = EV_PAYLOAD;
    res.command         = cmd_r;
    res.msg_number      = num_r;
    res.frame_length    = len_r;
    res.data_byte       = 8'd0;
    res.has_data        = 1'b0;
    res.last            = 1'b1;
    res.crc_error_count = errs_r;

    if (phase_r == PH_READ) begin
      // Stream the stored payload, one byte per queue slot.
      if (can_push) begin
        push           = 1'b1;
        res.data_byte  = rd_data_r;
        res.has_data   = 1'b1;
        res.last       = rd_last;
        rd_idx_nxt     = rd_idx_r + ADDR_W'(1);
        restart        = rd_last;
      end
    end else if (in_acc) begin
      if (in_if.kind) begin
        if (ticks_r != 8'd0) begin
          ticks_nxt = ticks_r - 8'd1;
        end else begin
          push          = 1'b1;
          res.event_res = EV_TIMEOUT;
          restart       = 1'b1;
        end
      end else begin
        ticks_nxt = tmo_r;
        unique case (phase_r)
          PH_CMD: begin
            cmd_nxt   = b[6:0];
            crc_nxt   = crc8_step(crc_r, b);
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            if (b > 8'(BUF_LEN - 1)) begin
              push             = 1'b1;
              res.event_res    = EV_ABORT;
              res.frame_length = b;
              restart          = 1'b1;
            end else begin
              len_nxt   = b;
              crc_nxt   = crc8_step(crc_r, b);
              phase_nxt = PH_NUM;
            end
          end
          PH_NUM: begin
            num_nxt   = b;
            crc_nxt   = crc8_step(crc_r, b);
            pidx_nxt  = '0;
            phase_nxt = (len_r == MIN_LEN) ? PH_CRC : PH_DATA;
          end
          PH_DATA: begin
            mem_we = 1'b1;
            // Drop the frame once the last slot of the buffer is filled.
            if (pidx_r == ADDR_W'(BUF_LEN - 1)) begin
              push          = 1'b1;
              res.event_res = EV_ABORT;
              restart       = 1'b1;
            end else begin
              pidx_nxt = pidx_r + ADDR_W'(1);
              crc_nxt  = crc8_step(crc_r, b);
              if ((8'(pidx_r) + 8'd6) == len_r) begin
                phase_nxt = PH_CRC;
              end
            end
          end
          PH_CRC: begin
            if (crc_r == b) begin
              if (pidx_r == '0) begin
                push    = 1'b1;
                restart = 1'b1;
              end else begin
                phase_nxt  = PH_READ;
                rd_idx_nxt = '0;
              end
            end else begin
              errs_nxt            = errs_r + 16'd1;
              push                = 1'b1;
              res.event_res       = EV_CRC_ERR;
              res.crc_error_count = errs_nxt;
              restart             = 1'b1;
            end
          end
          default: begin
            // Header search; spare codes behave the same.
            if (b == hdr_r) begin
              phase_nxt = PH_CMD;
              len_nxt   = MIN_LEN;
              crc_nxt   = crc8_step(crc_r, b);
            end else begin
              phase_nxt = PH_SEARCH;
            end
          end
        endcase
      end
    end

    if (restart) begin
      phase_nxt = PH_SEARCH;
      len_nxt   = MIN_LEN;
      crc_nxt   = 8'd0;
      cmd_nxt   = 7'd0;
      pidx_nxt  = '0;
      ticks_nxt = tmo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      len_r    <= MIN_LEN;
      crc_r    <= 8'd0;
      cmd_r    <= 7'd0;
      num_r    <= 8'd0;
      pidx_r   <= '0;
      ticks_r  <= TMO_RST;
      errs_r   <= 16'd0;
      rd_idx_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      crc_r    <= crc_nxt;
      cmd_r    <= cmd_nxt;
      num_r    <= num_nxt;
      pidx_r   <= pidx_nxt;
      ticks_r  <= ticks_nxt;
      errs_r   <= errs_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  // Payload memory: one write, one registered read addressed ahead by the readout index.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pay_mem_r[pidx_r] <= b;
    end
    rd_data_r <= pay_mem_r[rd_idx_nxt];
  end

  srfc_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (res),
    .can_push (can_push),
    .out_if   (out_if)
  );

`ifndef SYNTH
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push)
    else $error("result pushed into a full queue");

  a_read_end_search: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READ && push && res.last) |=> phase_r == PH_SEARCH)
    else $error("readout did not return to header search");

  a_err_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.event_res == EV_CRC_ERR) |=> errs_r == $past(errs_r) + 16'd1)
    else $error("CRC error count did not advance by one");

  a_read_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READ) |-> (rd_idx_r < pidx_r))
    else $error("readout index beyond stored payload");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(phase_r == PH_READ) |-> (pidx_r != '0 && rd_idx_r == '0))
    else $error("readout started without payload");
`endif

endmodule

// ===== test/srfc_frame_checker.sv =====
`timescale 1ns / 1ps
// CRC helper package and result checker for the framed serial receiver.
package srfc_tb_pkg;

  // Reflected CRC-8 register, data bits shifted in from the top
  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] din);
    logic [7:0] r;
    logic [7:0] d;
    r = acc;
    d = din;
    repeat (8) begin
      if (d[7] ^ r[0]) r = (r >> 1) ^ srfc_pkg::CRC_POLY;
      else r = r >> 1;
      d = d << 1;
    end
    return r;
  endfunction

endpackage

module srfc_frame_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  srfc_in_if                                  in_ch,
  srfc_out_if                                 out_ch,
  input  logic                                cfg_wr_en,
  input  logic [srfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srfc_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  output int                                  fail_count,
  output int                                  pending
);

  typedef enum logic [2:0] {
    HUNT      = 3'd0,
    TAKE_CMD  = 3'd1,
    TAKE_LEN  = 3'd2,
    TAKE_NUM  = 3'd3,
    TAKE_DATA = 3'd4,
    TAKE_CRC  = 3'd5
  } rx_phase_e;

  rx_phase_e  phase;
  logic [7:0] hdr_cfg;
  logic [7:0] reload_cfg;
  logic [7:0] want_len;
  logic [7:0] seen_cnt;
  logic [7:0] crc_acc;
  logic [6:0] frame_cmd;
  logic [7:0] frame_num;
  logic [5:0] pay_idx;
  logic [7:0] pay_mem [srfc_pkg::BUF_LEN];
  logic [7:0] ticks_left;
  logic [15:0] crc_errs;

  srfc_pkg::srfc_res_t expected_q[$];

  task automatic queue_result(input logic [1:0] ev, input logic [7:0] len,
                              input logic [7:0] data, input logic has, input logic fin);
    srfc_pkg::srfc_res_t r;
    r.event_res       = ev;
    r.command         = frame_cmd;
    r.msg_number      = frame_num;
    r.frame_length    = len;
    r.data_byte       = data;
    r.has_data        = has;
    r.last            = fin;
    r.crc_error_count = crc_errs;
    expected_q.push_back(r);
  endtask

  task automatic restart_hunt();
    phase      = HUNT;
    want_len   = srfc_pkg::MIN_LEN;
    seen_cnt   = 8'd0;
    crc_acc    = 8'd0;
    frame_cmd  = 7'd0;
    pay_idx    = 6'd0;
    ticks_left = reload_cfg;
  endtask

  task automatic step_frame(input logic tick, input logic [7:0] b);
    int idx;
    if (tick) begin
      if (ticks_left != 8'd0) begin
        ticks_left--;
      end else begin
        queue_result(srfc_pkg::EV_TIMEOUT, want_len, 8'd0, 1'b0, 1'b1);
        restart_hunt();
      end
    end else begin
      case (phase)
        TAKE_CMD: begin
          frame_cmd  = b[6:0];
          seen_cnt++;
          crc_acc    = srfc_tb_pkg::crc8_next(crc_acc, b);
          phase      = TAKE_LEN;
          ticks_left = reload_cfg;
        end
        TAKE_LEN: begin
          if (b > srfc_pkg::BUF_LEN - 1) begin
            queue_result(srfc_pkg::EV_ABORT, b, 8'd0, 1'b0, 1'b1);
            restart_hunt();
          end else begin
            want_len   = b;
            seen_cnt++;
            crc_acc    = srfc_tb_pkg::crc8_next(crc_acc, b);
            phase      = TAKE_NUM;
            ticks_left = reload_cfg;
          end
        end
        TAKE_NUM: begin
          frame_num  = b;
          seen_cnt++;
          crc_acc    = srfc_tb_pkg::crc8_next(crc_acc, b);
          pay_idx    = 6'd0;
          phase      = (int'(seen_cnt) + 1 == int'(want_len)) ? TAKE_CRC : TAKE_DATA;
          ticks_left = reload_cfg;
        end
        TAKE_DATA: begin
          idx = pay_idx;
          if (idx < srfc_pkg::BUF_LEN) pay_mem[idx] = b;
          idx++;
          // abort once the last buffer slot has been filled
          if (idx > srfc_pkg::BUF_LEN - 1) begin
            queue_result(srfc_pkg::EV_ABORT, want_len, 8'd0, 1'b0, 1'b1);
            restart_hunt();
          end else begin
            pay_idx = idx[5:0];
            crc_acc = srfc_tb_pkg::crc8_next(crc_acc, b);
            seen_cnt++;
            if (int'(seen_cnt) + 1 == int'(want_len)) phase = TAKE_CRC;
            ticks_left = reload_cfg;
          end
        end
        TAKE_CRC: begin
          if (crc_acc == b) begin
            if (pay_idx == 6'd0) begin
              queue_result(srfc_pkg::EV_PAYLOAD, want_len, 8'd0, 1'b0, 1'b1);
            end else begin
              for (int i = 0; i < int'(pay_idx); i++)
                queue_result(srfc_pkg::EV_PAYLOAD, want_len, pay_mem[i], 1'b1,
                             (i + 1 == int'(pay_idx)));
            end
          end else begin
            crc_errs++;
            queue_result(srfc_pkg::EV_CRC_ERR, want_len, 8'd0, 1'b0, 1'b1);
          end
          restart_hunt();
        end
        default: begin
          if (b == hdr_cfg) begin
            phase    = TAKE_CMD;
            want_len = srfc_pkg::MIN_LEN;
            seen_cnt = 8'd1;
            crc_acc  = srfc_tb_pkg::crc8_next(crc_acc, b);
          end else begin
            phase = HUNT;
          end
          ticks_left = reload_cfg;
        end
      endcase
    end
  endtask

  function automatic int field_bad(input string name, input logic [15:0] want,
                                   input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_result();
    srfc_pkg::srfc_res_t want;
    int bad;
    if (expected_q.size() == 0) begin
      $error("result with no request outstanding: event_res %0d", out_ch.event_res);
      fail_count++;
    end else begin
      want = expected_q.pop_front();
      bad = 0;
      bad += field_bad("event_res", 16'(want.event_res), 16'(out_ch.event_res));
      bad += field_bad("command", 16'(want.command), 16'(out_ch.command));
      bad += field_bad("msg_number", 16'(want.msg_number), 16'(out_ch.msg_number));
      bad += field_bad("frame_length", 16'(want.frame_length), 16'(out_ch.frame_length));
      bad += field_bad("data_byte", 16'(want.data_byte), 16'(out_ch.data_byte));
      bad += field_bad("has_data", 16'(want.has_data), 16'(out_ch.has_data));
      bad += field_bad("last", 16'(want.last), 16'(out_ch.last));
      bad += field_bad("crc_error_count", want.crc_error_count, out_ch.crc_error_count);
      fail_count += bad;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hdr_cfg      = srfc_pkg::HDR_RST;
      reload_cfg   = srfc_pkg::TMO_RST;
      frame_num    = 8'd0;
      crc_errs     = 16'd0;
      fail_count   = 0;
      expected_q.delete();
      restart_hunt();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == srfc_pkg::REG_HEADER) hdr_cfg = cfg_wr_data;
        else if (cfg_index == srfc_pkg::REG_TIMEOUT) reload_cfg = cfg_wr_data;
      end
      if (in_ch.valid && in_ch.ready) step_frame(in_ch.kind, in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) check_result();
    end
    pending = expected_q.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Stimulus, receiver pacing and final verdict for the framed serial receiver core.
module testbench;

  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 6;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_wr_en;
  logic [srfc_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [srfc_pkg::CFG_DATA_W-1:0]    cfg_wr_data;

  int   fail_count;
  int   pending;
  int   items_sent;
  int   phase_start;
  int   send_idle_pct = 0;
  int   sink_stall_pct = 0;
  logic hold_req = 1'b0;
  logic [7:0] hdr_val;
  logic [7:0] reload_val;

  srfc_in_if  in_ch ();
  srfc_out_if out_ch ();

  serial_frame_receiver_crc8_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  srfc_frame_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    logic hold_done;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done    = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_req(input logic tick, input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.kind    = tick;
    in_ch.rx_byte = b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid and hold until every expected result is back
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [srfc_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_index   = idx;
    cfg_wr_data = val;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    if (idx == srfc_pkg::REG_HEADER) hdr_val = val;
    else reload_val = val;
  endtask

  // Build a frame from the current header; crc_flip corrupts the check byte, cut truncates
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                            input logic [7:0] num, input logic [7:0] crc_flip, input int cut);
    logic [7:0] bytes_q[$];
    logic [7:0] acc;
    int pay_n;
    bytes_q.push_back(hdr_val);
    bytes_q.push_back(cmd);
    bytes_q.push_back(len);
    if (len <= srfc_pkg::BUF_LEN - 1) begin
      bytes_q.push_back(num);
      // short lengths never reach the check byte and overrun the buffer instead
      pay_n = (len < srfc_pkg::MIN_LEN) ? srfc_pkg::BUF_LEN : int'(len - srfc_pkg::MIN_LEN);
      repeat (pay_n) bytes_q.push_back(8'($urandom_range(255)));
      if (len >= srfc_pkg::MIN_LEN) begin
        acc = 8'd0;
        foreach (bytes_q[i]) acc = srfc_tb_pkg::crc8_next(acc, bytes_q[i]);
        bytes_q.push_back(acc ^ crc_flip);
      end
    end
    foreach (bytes_q[i]) begin
      if (cut == 0 || i < cut) begin
        if ($urandom_range(99) < 3) send_req(1'b1, 8'($urandom_range(255)));
        send_req(1'b0, bytes_q[i]);
      end
    end
  endtask

  task automatic run_scenario();
    int r;
    int n;
    logic [7:0] len;
    r = $urandom_range(99);
    len = ($urandom_range(9) == 0) ? 8'($urandom_range(31, 5)) : 8'($urandom_range(11, 5));
    if (r < 58) begin
      send_frame(8'($urandom_range(255)), len, 8'($urandom_range(255)), 8'd0, 0);
    end else if (r < 70) begin
      send_frame(8'($urandom_range(255)), len, 8'($urandom_range(255)),
                 8'($urandom_range(255, 1)), 0);
    end else if (r < 76) begin
      send_frame(8'($urandom_range(255)), 8'($urandom_range(255, 32)),
                 8'($urandom_range(255)), 8'd0, 0);
    end else if (r < 79) begin
      send_frame(8'($urandom_range(255)), 8'($urandom_range(4, 0)),
                 8'($urandom_range(255)), 8'd0, 0);
    end else if (r < 86) begin
      // truncated frame, then enough ticks to time out where the reload allows it
      send_frame(8'($urandom_range(255)), len, 8'($urandom_range(255)), 8'd0,
                 $urandom_range(4, 1));
      n = (reload_val < 8'd11) ? int'(reload_val) + 1 : 12;
      repeat (n) send_req(1'b1, 8'($urandom_range(255)));
    end else if (r < 93) begin
      repeat ($urandom_range(3, 1)) send_req(1'b1, 8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(3, 1)) send_req(1'b0, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = srfc_pkg::REG_HEADER;
    cfg_wr_data   = '0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = 1'b0;
    in_ch.rx_byte = 8'd0;
    hdr_val       = srfc_pkg::HDR_RST;
    reload_val    = srfc_pkg::TMO_RST;
    items_sent    = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed: noise, empty frame, short payload, bad check byte, oversize length
    send_req(1'b0, 8'hFF);
    send_frame(8'hFF, 8'd5, 8'hFF, 8'd0, 0);
    send_frame(8'h00, 8'd7, 8'h00, 8'd0, 0);
    send_frame(8'h80, 8'd6, 8'h7F, 8'hFF, 0);
    send_frame(8'h55, 8'd32, 8'h00, 8'd0, 0);
    wait_idle();
    write_reg(srfc_pkg::REG_TIMEOUT, 8'd0);
    send_req(1'b1, 8'h00);
    wait_idle();
    write_reg(srfc_pkg::REG_TIMEOUT, srfc_pkg::TMO_RST);
    send_frame(8'($urandom_range(255)), 8'd4, 8'($urandom_range(255)), 8'd0, 0);

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_reg(srfc_pkg::REG_HEADER, 8'hFF);
          write_reg(srfc_pkg::REG_TIMEOUT, 8'hFF);
          send_idle_pct  = 0;
          sink_stall_pct = 0;
        end
        1: begin
          write_reg(srfc_pkg::REG_HEADER, 8'h00);
          write_reg(srfc_pkg::REG_TIMEOUT, 8'd0);
          send_idle_pct  = 87;
          sink_stall_pct = 0;
        end
        2: begin
          write_reg(srfc_pkg::REG_HEADER, 8'($urandom_range(255)));
          write_reg(srfc_pkg::REG_TIMEOUT, 8'($urandom_range(15, 1)));
          send_idle_pct  = 0;
          sink_stall_pct = 87;
        end
        default: begin
          write_reg(srfc_pkg::REG_HEADER, srfc_pkg::HDR_RST);
          write_reg(srfc_pkg::REG_TIMEOUT, 8'd5);
          send_idle_pct  = 29;
          sink_stall_pct = 29;
        end
      endcase
      if (p == 0) begin
        // hold the result side while frames keep coming, so the input backs up
        hold_req = 1'b1;
        send_frame(8'($urandom_range(255)), 8'd17, 8'($urandom_range(255)), 8'd0, 0);
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_scenario();
    end

    in_ch.valid = 1'b0;
    for (int i = 0; i < 100000 && pending != 0; i++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      if (pending != 0) $error("%0d expected results never arrived", pending);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
